[hdl/ecs_pkg.sv]
// shared types, constants and calendar helpers for the epoch seconds to calendar block
// no dependencies; imported by ecs_front, ecs_back and the top level of the block
package ecs_pkg;

   // field widths of the transactions
   localparam int EPOCH_FIELD_BITS  = 32;
   localparam int YEAR_BITS         = 12;
   localparam int MONTH_BITS        = 4;
   localparam int DAY_OF_MONTH_BITS = 5;
   localparam int HOUR_BITS         = 5;
   localparam int MINUTE_BITS       = 6;
   localparam int SECOND_BITS       = 6;

   // time constants
   localparam int unsigned SECS_PER_MIN  = 60;
   localparam int unsigned SECS_PER_HOUR = 60 * 60;
   localparam int unsigned SECS_PER_DAY  = 24 * 60 * 60;
   // 2**16 < seconds per day < 2**17, so a day count needs 16 bits fewer than seconds
   localparam int DAY_SHIFT = 16;

   // calendar constants
   localparam logic [YEAR_BITS-1:0] EPOCH_YEAR     = 12'd1970;
   localparam logic [8:0]           LEAP_CYCLE     = 9'd400;
   localparam logic [8:0]           CENTURY        = 9'd100;
   localparam logic [8:0]           EPOCH_M400     = 9'd370;
   localparam int unsigned          YEAR_DAYS      = 365;
   localparam int unsigned          LEAP_YEAR_DAYS = 366;
   localparam logic [MONTH_BITS-1:0] FEB_IDX       = 4'd1;
   localparam logic [MONTH_BITS-1:0] LAST_MONTH_IDX = 4'd11;

   // time of day carried from the front to the back
   typedef struct packed {
      logic [HOUR_BITS-1:0]   hour;
      logic [MINUTE_BITS-1:0] minute;
      logic [SECOND_BITS-1:0] second;
   } tod_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_DAYS,
      F_DAY_REM,
      F_HOURS,
      F_HOUR_REM,
      F_MINS,
      F_MIN_REM,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_YEAR,
      B_MONTH,
      B_DONE
   } back_state_type;

   // leap test on the year taken modulo 400
   function automatic logic is_leap_m400(input logic [8:0] m400);
      logic div4;
      logic century;
      div4    = (m400[1:0] == 2'd0);
      century = (m400 == CENTURY) || (m400 == 9'(2 * CENTURY)) || (m400 == 9'(3 * CENTURY));
      return div4 && !century;
   endfunction

   // days in a month, month index 0 is january
   function automatic logic [DAY_OF_MONTH_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] idx,
                                                             input logic leap);
      logic [DAY_OF_MONTH_BITS-1:0] len;
      unique case (idx)
         FEB_IDX: len = leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

[hdl/ecs_queue.sv]
// small register queue between the front and the back of the block
// depends on nothing; depth must be a power of two
module ecs_queue #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   // status and pointer update
   always_comb begin
      full      = (count_ff == CNT_BITS'(DEPTH));
      empty     = (count_ff == '0);
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
      rd_data = mem_ff[rd_ptr_ff];
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[hdl/ecs_front.sv]
// front part: accepts seconds and splits them into days, hour, minute and second
// by reciprocal multiplication, one quotient or remainder step a cycle; uses ecs_pkg
module ecs_front #(
   parameter int EFF_BITS = 32,
   parameter int DAY_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [ecs_pkg::EPOCH_FIELD_BITS-1:0] req_epoch_seconds,
   output logic                                 q_push,
   input  logic                                 q_full,
   output logic [DAY_BITS-1:0]                  q_days,
   output ecs_pkg::tod_type                     q_tod
);

   import ecs_pkg::*;

   // days: (seconds >> 7) / 675, exact for shifted counts below 2**25
   localparam int          DAY_POW2      = 7;
   localparam int          DAY_RSHIFT    = 35;
   localparam logic [25:0] DAY_RECIP     = 26'd50903317;
   localparam int          DAY_PROD_BITS = EFF_BITS - DAY_POW2 + 26;
   // hours: (rem >> 4) / 225, rem below one day
   localparam int          DAY_REM_BITS   = 17;
   localparam int          HOUR_POW2      = 4;
   localparam int          HOUR_RSHIFT    = 21;
   localparam logic [13:0] HOUR_RECIP     = 14'd9321;
   localparam int          HOUR_PROD_BITS = DAY_REM_BITS - HOUR_POW2 + 14;
   // minutes: (rem >> 2) / 15, rem below one hour
   localparam int          HOUR_REM_BITS = 12;
   localparam int          MIN_POW2      = 2;
   localparam int          MIN_RSHIFT    = 14;
   localparam logic [10:0] MIN_RECIP     = 11'd1093;
   localparam int          MIN_PROD_BITS = HOUR_REM_BITS - MIN_POW2 + 11;

   localparam logic [EFF_BITS-1:0] DAY_SECS  = EFF_BITS'(SECS_PER_DAY);
   localparam logic [EFF_BITS-1:0] HOUR_SECS = EFF_BITS'(SECS_PER_HOUR);
   localparam logic [EFF_BITS-1:0] MIN_SECS  = EFF_BITS'(SECS_PER_MIN);

   front_state_type           state_ff, state_in;
   logic [EFF_BITS-1:0]       rem_ff, rem_in;
   logic [DAY_BITS-1:0]       days_ff, days_in;
   logic [HOUR_BITS-1:0]      hour_ff, hour_in;
   logic [MINUTE_BITS-1:0]    minute_ff, minute_in;
   logic [DAY_PROD_BITS-1:0]  day_prod;
   logic [HOUR_PROD_BITS-1:0] hour_prod;
   logic [MIN_PROD_BITS-1:0]  min_prod;

   // reciprocal products for the three quotients
   always_comb begin
      day_prod  = DAY_PROD_BITS'(rem_ff[EFF_BITS-1:DAY_POW2]) * DAY_PROD_BITS'(DAY_RECIP);
      hour_prod = HOUR_PROD_BITS'(rem_ff[DAY_REM_BITS-1:HOUR_POW2])
                  * HOUR_PROD_BITS'(HOUR_RECIP);
      min_prod  = MIN_PROD_BITS'(rem_ff[HOUR_REM_BITS-1:MIN_POW2])
                  * MIN_PROD_BITS'(MIN_RECIP);
   end

   // sequencer: each unit takes a quotient state and a remainder state, then hand off
   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      days_in   = days_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      req_full  = 1'b1;
      q_push    = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            req_full = 1'b0;
            if (req_push) begin
               rem_in   = req_epoch_seconds[EFF_BITS-1:0];
               state_in = F_DAYS;
            end
         end
         F_DAYS: begin
            days_in  = day_prod[DAY_RSHIFT +: DAY_BITS];
            state_in = F_DAY_REM;
         end
         F_DAY_REM: begin
            rem_in   = rem_ff - EFF_BITS'(days_ff) * DAY_SECS;
            state_in = F_HOURS;
         end
         F_HOURS: begin
            hour_in  = hour_prod[HOUR_RSHIFT +: HOUR_BITS];
            state_in = F_HOUR_REM;
         end
         F_HOUR_REM: begin
            rem_in   = rem_ff - EFF_BITS'(hour_ff) * HOUR_SECS;
            state_in = F_MINS;
         end
         F_MINS: begin
            minute_in = min_prod[MIN_RSHIFT +: MINUTE_BITS];
            state_in  = F_MIN_REM;
         end
         F_MIN_REM: begin
            rem_in   = rem_ff - EFF_BITS'(minute_ff) * MIN_SECS;
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // queue payload
   always_comb begin
      q_days        = days_ff;
      q_tod.hour    = hour_ff;
      q_tod.minute  = minute_ff;
      q_tod.second  = rem_ff[SECOND_BITS-1:0];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      days_ff   <= days_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
   end

   // remainder stays below the current unit once the larger unit is split off
   a_rem_below_day: assert property (@(posedge clock) disable iff (reset)
      (state_ff == F_HOURS) |-> (rem_ff < EFF_BITS'(SECS_PER_DAY)))
      else $error("remainder not below one day in hour phase");

   a_rem_below_hour: assert property (@(posedge clock) disable iff (reset)
      (state_ff == F_MINS) |-> (rem_ff < EFF_BITS'(SECS_PER_HOUR) && hour_ff < 5'd24))
      else $error("remainder or hour out of range in minute phase");

   a_rem_below_min: assert property (@(posedge clock) disable iff (reset)
      (state_ff == F_PUSH) |-> (rem_ff < EFF_BITS'(SECS_PER_MIN) && minute_ff < 6'd60))
      else $error("second or minute out of range at hand off");

endmodule

[hdl/ecs_back.sv]
// back part: walks the day count through years and months, holds the result transaction
// uses ecs_pkg; fed from the queue behind the front
module ecs_back #(
   parameter int DAY_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_empty,
   output logic                                  q_pop,
   input  logic [DAY_BITS-1:0]                   q_days,
   input  ecs_pkg::tod_type                      q_tod,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic [ecs_pkg::YEAR_BITS-1:0]         rsp_year,
   output logic [ecs_pkg::MONTH_BITS-1:0]        rsp_month,
   output logic [ecs_pkg::DAY_OF_MONTH_BITS-1:0] rsp_day_of_month,
   output logic [ecs_pkg::HOUR_BITS-1:0]         rsp_hour,
   output logic [ecs_pkg::MINUTE_BITS-1:0]       rsp_minute,
   output logic [ecs_pkg::SECOND_BITS-1:0]       rsp_second
);

   import ecs_pkg::*;

   back_state_type              state_ff, state_in;
   logic [DAY_BITS-1:0]         days_ff, days_in;
   logic [YEAR_BITS-1:0]        year_ff, year_in;
   logic [8:0]                  m400_ff, m400_in;
   logic [MONTH_BITS-1:0]       mon_ff, mon_in;
   tod_type                     tod_ff, tod_in;
   logic                        out_valid_ff, out_valid_in;
   logic                        load_out;
   logic                        leap;
   logic [DAY_BITS-1:0]         year_len;
   logic [DAY_BITS-1:0]         mon_len;
   logic                        out_free;
   logic [YEAR_BITS-1:0]        out_year_ff;
   logic [MONTH_BITS-1:0]       out_month_ff;
   logic [DAY_OF_MONTH_BITS-1:0] out_day_ff;
   tod_type                     out_tod_ff;

   // lengths of the current year and month
   always_comb begin
      leap     = is_leap_m400(m400_ff);
      year_len = leap ? DAY_BITS'(LEAP_YEAR_DAYS) : DAY_BITS'(YEAR_DAYS);
      mon_len  = DAY_BITS'(month_len(mon_ff, leap));
      out_free = !out_valid_ff || rsp_pop;
   end

   // year walk, then month walk, then result register
   always_comb begin
      state_in     = state_ff;
      days_in      = days_ff;
      year_in      = year_ff;
      m400_in      = m400_ff;
      mon_in       = mon_ff;
      tod_in       = tod_ff;
      q_pop        = 1'b0;
      load_out     = 1'b0;
      out_valid_in = out_valid_ff && !rsp_pop;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               days_in  = q_days;
               tod_in   = q_tod;
               year_in  = EPOCH_YEAR;
               m400_in  = EPOCH_M400;
               mon_in   = '0;
               state_in = B_YEAR;
            end
         end
         B_YEAR: begin
            if (days_ff < year_len) begin
               state_in = B_MONTH;
            end else begin
               days_in = days_ff - year_len;
               year_in = year_ff + 1'b1;
               m400_in = (m400_ff == LEAP_CYCLE - 9'd1) ? 9'd0 : m400_ff + 9'd1;
            end
         end
         B_MONTH: begin
            if (mon_ff == LAST_MONTH_IDX || days_ff < mon_len) begin
               state_in = B_DONE;
            end else begin
               days_in = days_ff - mon_len;
               mon_in  = mon_ff + 1'b1;
            end
         end
         B_DONE: begin
            if (out_free) begin
               load_out     = 1'b1;
               out_valid_in = 1'b1;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // walk registers and result register
   always_ff @(posedge clock) begin
      days_ff <= days_in;
      year_ff <= year_in;
      m400_ff <= m400_in;
      mon_ff  <= mon_in;
      tod_ff  <= tod_in;
      if (load_out) begin
         out_year_ff  <= year_ff;
         out_month_ff <= mon_ff + 1'b1;
         out_day_ff   <= days_ff[DAY_OF_MONTH_BITS-1:0] + 1'b1;
         out_tod_ff   <= tod_ff;
      end
   end

   // result ports
   always_comb begin
      rsp_empty        = !out_valid_ff;
      rsp_year         = out_year_ff;
      rsp_month        = out_month_ff;
      rsp_day_of_month = out_day_ff;
      rsp_hour         = out_tod_ff.hour;
      rsp_minute       = out_tod_ff.minute;
      rsp_second       = out_tod_ff.second;
   end

   // the modulo 400 counter tracks the year
   a_m400_tracks_year: assert property (@(posedge clock) disable iff (reset)
      (state_ff != B_IDLE) |-> (year_ff[1:0] == m400_ff[1:0]))
      else $error("leap cycle counter out of step with year");

   // month walk starts with less than a year of days and stays in range
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_MONTH) |-> (days_ff < DAY_BITS'(LEAP_YEAR_DAYS) && mon_ff <= LAST_MONTH_IDX))
      else $error("month walk out of range");

   // a held result only leaves when taken
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      $fell(out_valid_ff) |-> ($past(rsp_pop) || $past(reset)))
      else $error("result dropped without a pop");

endmodule

[hdl/epoch_seconds_to_calendar.sv]
// top level of the epoch seconds to calendar converter
// instantiates ecs_front, ecs_queue and ecs_back; uses ecs_pkg
//
// Usage: push a count of seconds since 1970-01-01 00:00:00 UTC on req_epoch_seconds with
// req_push while req_full is low. Each transaction gives exactly one result: year, month,
// day of month, hour, minute and second, shown on the rsp_ ports while rsp_empty is low
// and taken with rsp_pop. Bits of the seconds at and above SECONDS_BITS are ignored.
// Front: reciprocal multiplies split off days, hour and minute, one quotient or one
// remainder step a cycle through F_DAYS, F_DAY_REM, F_HOURS, F_HOUR_REM, F_MINS and
// F_MIN_REM; F_PUSH then hands off into a two entry queue, waiting while it is full, and
// the front returns to F_IDLE before it takes the next transaction. Back: one cycle per
// whole year since 1970 and one per whole month, plus a step in B_IDLE to take the
// transaction, the last steps of B_YEAR and B_MONTH to end each walk and B_DONE to
// register the result. The front overlaps the next transaction with the back's walks.
// Reset clears all control state; the queue and result register come up empty.
// When the receiver stalls, the result register holds, the back waits with the next
// result finished, the queue fills and req_full rises; nothing is dropped.
module epoch_seconds_to_calendar #(
   parameter int SECONDS_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [ecs_pkg::EPOCH_FIELD_BITS-1:0]  req_epoch_seconds,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic [ecs_pkg::YEAR_BITS-1:0]         rsp_year,
   output logic [ecs_pkg::MONTH_BITS-1:0]        rsp_month,
   output logic [ecs_pkg::DAY_OF_MONTH_BITS-1:0] rsp_day_of_month,
   output logic [ecs_pkg::HOUR_BITS-1:0]         rsp_hour,
   output logic [ecs_pkg::MINUTE_BITS-1:0]       rsp_minute,
   output logic [ecs_pkg::SECOND_BITS-1:0]       rsp_second
);

   import ecs_pkg::*;

   localparam int EFF_BITS    = (SECONDS_BITS < EPOCH_FIELD_BITS) ? SECONDS_BITS
                                                                   : EPOCH_FIELD_BITS;
   localparam int DAY_BITS    = EFF_BITS - DAY_SHIFT;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_WIDTH = DAY_BITS + $bits(tod_type);

   logic                   q_push, q_full, q_pop, q_empty;
   logic [DAY_BITS-1:0]    front_days, back_days;
   tod_type                front_tod, back_tod;
   logic [QUEUE_WIDTH-1:0] q_wr_data, q_rd_data;

   // seconds split into days and time of day
   ecs_front #(
      .EFF_BITS (EFF_BITS),
      .DAY_BITS (DAY_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_epoch_seconds (req_epoch_seconds),
      .q_push            (q_push),
      .q_full            (q_full),
      .q_days            (front_days),
      .q_tod             (front_tod)
   );

   // queue between front and back
   assign q_wr_data = {front_days, front_tod};
   assign back_days = q_rd_data[QUEUE_WIDTH-1 -: DAY_BITS];
   assign back_tod  = q_rd_data[$bits(tod_type)-1:0];

   ecs_queue #(
      .WIDTH (QUEUE_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .full    (q_full),
      .wr_data (q_wr_data),
      .pop     (q_pop),
      .empty   (q_empty),
      .rd_data (q_rd_data)
   );

   // year and month walk with result register
   ecs_back #(
      .DAY_BITS (DAY_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .q_days           (back_days),
      .q_tod            (back_tod),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second)
   );

endmodule
